@@ hdl/miller_rabin_witness_round_defines.svh @@
// Assertion macros for the Miller-Rabin witness round block.
// Included by the top level; needs signals clk and arst_n in scope.
`ifndef MILLER_RABIN_WITNESS_ROUND_DEFINES_SVH
`define MILLER_RABIN_WITNESS_ROUND_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define MRW_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: same-cycle check failed");
`define MRW_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");
`else
`define MRW_ASSERT_IMPL(label, ante, cons)
`define MRW_ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ hdl/mrw_pkg.sv @@
// Shared types and constants of the Miller-Rabin witness round block.
// Used by mrw_mulmod and miller_rabin_witness_round; no dependencies.
package mrw_pkg;

	localparam int NUM_BITS_DEF = 63;
	localparam int FIELD_W      = 63;
	localparam int EXT_W        = 64;
	localparam int S_TDATA_W    = 128;
	localparam int M_TDATA_W    = 8;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SPLIT,
		ST_RED_GO,
		ST_RED_WAIT,
		ST_POW_CHECK,
		ST_ACC_GO,
		ST_ACC_WAIT,
		ST_SQB_GO,
		ST_SQB_WAIT,
		ST_FIN_CHECK,
		ST_SQ_CHECK,
		ST_SQR_GO,
		ST_SQR_WAIT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} mm_stat_t;

endpackage

@@ hdl/mrw_mulmod.sv @@
// Bit-serial modular multiplier: r = x * y mod n, one bit of y per cycle.
// Depends on mrw_pkg; requires x < n and n >= 2, y of any value.
module mrw_mulmod #(
	parameter int NUM_BITS = mrw_pkg::NUM_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [NUM_BITS-1:0] x,
	input  logic [NUM_BITS-1:0] y,
	input  logic [NUM_BITS-1:0] n,
	output mrw_pkg::mm_stat_t   stat,
	output logic [NUM_BITS-1:0] result
);

	localparam int SW = NUM_BITS + 2;
	localparam int CW = $clog2(NUM_BITS + 1);

	logic [NUM_BITS-1:0] r_q;
	logic [NUM_BITS-1:0] x_q;
	logic [NUM_BITS-1:0] y_q;
	logic [CW-1:0]       cnt_q;
	logic                busy_q;
	logic                done_q;

	logic [SW-1:0] sum;
	logic [SW-1:0] n1;
	logic [SW-1:0] n2;
	logic [SW-1:0] red;

	assign n1  = {2'b00, n};
	assign n2  = {1'b0, n, 1'b0};
	assign sum = {1'b0, r_q, 1'b0} + (y_q[NUM_BITS-1] ? {2'b00, x_q} : '0);

	always_comb begin
		if (sum >= n2) begin
			red = sum - n2;
		end else if (sum >= n1) begin
			red = sum - n1;
		end else begin
			red = sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NUM_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r_q <= '0;
			x_q <= x;
			y_q <= y;
		end else if (busy_q) begin
			r_q <= red[NUM_BITS-1:0];
			y_q <= y_q << 1;
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign result    = r_q;

endmodule

@@ hdl/miller_rabin_witness_round.sv @@
// Miller-Rabin witness round: top level with sequencer and round state.
// Depends on mrw_pkg, mrw_mulmod and miller_rabin_witness_round_defines.svh.
//
// channel  dir  handshake          payload
// s_*      in   s_tvalid/s_tready  tdata: candidate, witness_base
// m_*      out  m_tvalid/m_tready  tdata: probably_prime, too_small
//
// Each item runs the odd-part split, the base reduction, the square-and-multiply
// loop over d and the squaring loop over the trailing zeros of n-1, all on the
// one shared bit-serial multiplier. A new candidate is accepted only in IDLE.
// Candidates below four go straight to DONE. Reset clears the sequencer and
// the output valid. A stalled output holds the finished item in DONE.
`include "miller_rabin_witness_round_defines.svh"

module miller_rabin_witness_round #(
	parameter int NUM_BITS = mrw_pkg::NUM_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [mrw_pkg::S_TDATA_W-1:0]  s_tdata, // candidate[62:0], witness_base[125:63]
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [mrw_pkg::M_TDATA_W-1:0]  m_tdata  // probably_prime[0], too_small[1]
);

	localparam int KW = $clog2(NUM_BITS);

	mrw_pkg::state_t state_q, state_nxt;

	logic [NUM_BITS-1:0] n_q;
	logic [NUM_BITS-1:0] nm1_q;
	logic [NUM_BITS-1:0] a_q;
	logic [NUM_BITS-1:0] e_q;
	logic [NUM_BITS-1:0] acc_q;
	logic [NUM_BITS-1:0] base_q;
	logic [KW-1:0]       k_q;
	logic [KW-1:0]       i_q;
	logic                pass_q;
	logic                small_q;
	logic                out_pass_q;
	logic                out_small_q;
	logic                m_tvalid_q;

	logic [mrw_pkg::EXT_W-1:0] cand_ext;
	logic [mrw_pkg::EXT_W-1:0] wit_ext;
	logic [NUM_BITS-1:0]       n_in;
	logic [NUM_BITS-1:0]       a_in;
	logic                      in_small;
	logic                      accept;
	logic                      out_load;

	logic                mm_start;
	logic [NUM_BITS-1:0] mm_x;
	logic [NUM_BITS-1:0] mm_y;
	mrw_pkg::mm_stat_t   mm_stat;
	logic [NUM_BITS-1:0] mm_result;

	assign cand_ext = {{(mrw_pkg::EXT_W - mrw_pkg::FIELD_W){1'b0}},
		s_tdata[mrw_pkg::FIELD_W-1:0]};
	assign wit_ext  = {{(mrw_pkg::EXT_W - mrw_pkg::FIELD_W){1'b0}},
		s_tdata[2*mrw_pkg::FIELD_W-1:mrw_pkg::FIELD_W]};
	assign n_in     = cand_ext[NUM_BITS-1:0];
	assign a_in     = wit_ext[NUM_BITS-1:0];
	assign in_small = (n_in < NUM_BITS'(4));
	assign accept   = s_tvalid && s_tready;
	assign out_load = (state_q == mrw_pkg::ST_DONE) && (!m_tvalid_q || m_tready);

	mrw_mulmod #(
		.NUM_BITS(NUM_BITS)
	) u_mulmod (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mm_start),
		.x     (mm_x),
		.y     (mm_y),
		.n     (n_q),
		.stat  (mm_stat),
		.result(mm_result)
	);

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			mrw_pkg::ST_IDLE: begin
				if (accept) begin
					state_nxt = in_small ? mrw_pkg::ST_DONE : mrw_pkg::ST_SPLIT;
				end
			end
			mrw_pkg::ST_SPLIT: begin
				if (e_q[0]) begin
					state_nxt = mrw_pkg::ST_RED_GO;
				end
			end
			mrw_pkg::ST_RED_GO:   state_nxt = mrw_pkg::ST_RED_WAIT;
			mrw_pkg::ST_RED_WAIT: begin
				if (mm_stat.done) begin
					state_nxt = mrw_pkg::ST_POW_CHECK;
				end
			end
			mrw_pkg::ST_POW_CHECK: begin
				if (e_q == '0) begin
					state_nxt = mrw_pkg::ST_FIN_CHECK;
				end else if (e_q[0]) begin
					state_nxt = mrw_pkg::ST_ACC_GO;
				end else begin
					state_nxt = mrw_pkg::ST_SQB_GO;
				end
			end
			mrw_pkg::ST_ACC_GO:   state_nxt = mrw_pkg::ST_ACC_WAIT;
			mrw_pkg::ST_ACC_WAIT: begin
				if (mm_stat.done) begin
					state_nxt = mrw_pkg::ST_SQB_GO;
				end
			end
			mrw_pkg::ST_SQB_GO:   state_nxt = mrw_pkg::ST_SQB_WAIT;
			mrw_pkg::ST_SQB_WAIT: begin
				if (mm_stat.done) begin
					state_nxt = mrw_pkg::ST_POW_CHECK;
				end
			end
			mrw_pkg::ST_FIN_CHECK: begin
				state_nxt = (acc_q == NUM_BITS'(1)) ? mrw_pkg::ST_DONE : mrw_pkg::ST_SQ_CHECK;
			end
			mrw_pkg::ST_SQ_CHECK: begin
				if (acc_q == nm1_q || i_q == k_q) begin
					state_nxt = mrw_pkg::ST_DONE;
				end else begin
					state_nxt = mrw_pkg::ST_SQR_GO;
				end
			end
			mrw_pkg::ST_SQR_GO:   state_nxt = mrw_pkg::ST_SQR_WAIT;
			mrw_pkg::ST_SQR_WAIT: begin
				if (mm_stat.done) begin
					state_nxt = mrw_pkg::ST_SQ_CHECK;
				end
			end
			mrw_pkg::ST_DONE: begin
				if (out_load) begin
					state_nxt = mrw_pkg::ST_IDLE;
				end
			end
			default: state_nxt = mrw_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		mm_start = 1'b0;
		mm_x     = '0;
		mm_y     = '0;
		unique case (state_q)
			mrw_pkg::ST_IDLE: s_tready = 1'b1;
			mrw_pkg::ST_RED_GO: begin
				mm_start = 1'b1;
				mm_x     = NUM_BITS'(1);
				mm_y     = a_q;
			end
			mrw_pkg::ST_ACC_GO: begin
				mm_start = 1'b1;
				mm_x     = acc_q;
				mm_y     = base_q;
			end
			mrw_pkg::ST_SQB_GO: begin
				mm_start = 1'b1;
				mm_x     = base_q;
				mm_y     = base_q;
			end
			mrw_pkg::ST_SQR_GO: begin
				mm_start = 1'b1;
				mm_x     = acc_q;
				mm_y     = acc_q;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= mrw_pkg::ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_pass_q  <= pass_q;
			out_small_q <= small_q;
		end
		unique case (state_q)
			mrw_pkg::ST_IDLE: begin
				if (accept) begin
					n_q     <= n_in;
					nm1_q   <= n_in - NUM_BITS'(1);
					e_q     <= n_in - NUM_BITS'(1);
					a_q     <= a_in;
					acc_q   <= NUM_BITS'(1);
					k_q     <= '0;
					i_q     <= '0;
					pass_q  <= 1'b0;
					small_q <= in_small;
				end
			end
			mrw_pkg::ST_SPLIT: begin
				if (!e_q[0]) begin
					e_q <= e_q >> 1;
					k_q <= k_q + KW'(1);
				end
			end
			mrw_pkg::ST_RED_WAIT: begin
				if (mm_stat.done) begin
					base_q <= mm_result;
				end
			end
			mrw_pkg::ST_ACC_WAIT: begin
				if (mm_stat.done) begin
					acc_q <= mm_result;
				end
			end
			mrw_pkg::ST_SQB_WAIT: begin
				if (mm_stat.done) begin
					base_q <= mm_result;
					e_q    <= e_q >> 1;
				end
			end
			mrw_pkg::ST_FIN_CHECK: begin
				if (acc_q == NUM_BITS'(1)) begin
					pass_q <= 1'b1;
				end
			end
			mrw_pkg::ST_SQ_CHECK: begin
				if (i_q != k_q) begin
					if (acc_q == nm1_q) begin
						pass_q <= 1'b1;
					end else begin
						i_q <= i_q + KW'(1);
					end
				end
			end
			mrw_pkg::ST_SQR_WAIT: begin
				if (mm_stat.done) begin
					acc_q <= mm_result;
				end
			end
			default: begin
				pass_q <= pass_q;
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(mrw_pkg::M_TDATA_W - 2){1'b0}}, out_small_q, out_pass_q};

	`MRW_ASSERT_IMPL(a_busy_not_ready, mm_stat.busy, !s_tready)
	`MRW_ASSERT_IMPL(a_start_when_free, mm_start, !mm_stat.busy)
	`MRW_ASSERT_IMPL(a_small_fails, m_tvalid && m_tdata[1], !m_tdata[0])
	`MRW_ASSERT_NEXT(a_accept_leaves_idle, accept, state_q != mrw_pkg::ST_IDLE)

endmodule
